FILE: hw/rtl/bmp_stream_deframer_assert.svh
// assertion macros for the bmp stream deframer checker
// expects clk and rst in scope where a macro is used
`ifndef BMP_STREAM_DEFRAMER_ASSERT_SVH
`define BMP_STREAM_DEFRAMER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define BSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define BSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bsd_pkg.sv
// shared constants and codes for the bmp stream deframer
// no dependencies
`timescale 1ns / 1ps

package bsd_pkg;

  // result word kinds
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // error codes carried by an error word
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_SIGNATURE = 2'd1,
    ERR_TRUNCATED = 2'd2,
    ERR_OFFSET    = 2'd3
  } err_t;

  // file header layout
  localparam logic [31:0] HEADER_LEN      = 32'd54;
  localparam logic [5:0]  HEADER_LAST_IDX = 6'(HEADER_LEN - 32'd1);
  localparam logic [7:0]  SIG_B           = 8'h42;
  localparam logic [7:0]  SIG_M           = 8'h4D;

endpackage

FILE: hw/rtl/bmp_stream_deframer.sv
// A byte accepted into the input register gives its result word from the result register.
// Throughput: one byte per cycle while out accepts; a byte with no result drains even while out is stalled.
// A spare input register lets one byte in while a finished result waits for out_ready.
// Rate is set by the single per-byte header/skip/row/pad sequencer step.
// Reset (rst, synchronous): sequencer back to header phase, all counters and stores cleared.
`timescale 1ns / 1ps

// top level: header parse, offset skip and row padding strip of a 24-bit bmp byte stream
// depends on bsd_pkg
module bmp_stream_deframer
  import bsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_stream,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic [7:0]         pixel_byte,
  output logic               row_end,
  output logic               image_end,
  output logic signed [31:0] image_width,
  output logic signed [31:0] image_height,
  output logic [15:0]        pixel_bits,
  output logic [31:0]        pixel_data_offset,
  output logic [1:0]         error_code
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_ROW,
    PH_PAD,
    PH_WAIT
  } phase_t;

  // input register
  logic       ib_valid;
  logic [7:0] ib_data;
  logic       ib_eos;

  // sequencer state
  phase_t      phase, phase_next;
  logic [5:0]  header_index, header_index_next;
  logic [31:0] offset_store, offset_store_next;
  logic [31:0] width_store, width_store_next;
  logic [31:0] height_store, height_store_next;
  logic [15:0] bits_store, bits_store_next;
  logic [31:0] stream_position, stream_position_next;
  logic [32:0] row_byte_count, row_byte_count_next;
  logic [1:0]  pad_count, pad_count_next;
  logic [31:0] row_count, row_count_next;

  // result of the current byte
  logic        res_valid;
  kind_t       res_kind;
  logic        res_row_end;
  logic        res_image_end;
  err_t        res_err;

  logic        out_free;
  logic        step;

  // helpers
  logic [31:0] pos_inc;
  logic [32:0] row_len;
  logic [1:0]  lane;
  logic        w_pos, h_pos, empty;
  logic        last_row_byte, last_image;
  logic        clear;
  logic [1:0]  pad_dec;

  // handshake: byte moves on when the result slot is free or it yields no word
  assign out_free = !out_valid || out_ready;
  assign step     = ib_valid && (out_free || !res_valid);
  assign in_ready = !ib_valid || step;

  assign pos_inc = stream_position + 32'd1;
  assign row_len = {1'b0, width_store} + {width_store, 1'b0};
  assign lane    = header_index[1:0] - 2'd2;
  assign w_pos   = !width_store[31] && (width_store != 32'd0);
  assign h_pos   = !height_store[31] && (height_store != 32'd0);
  assign empty   = !(w_pos && h_pos);
  assign last_row_byte = (row_byte_count <= 33'd1);
  assign last_image    = last_row_byte && (row_count <= 32'd1);
  assign pad_dec = pad_count - 2'd1;

  // per-byte sequencer step
  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    offset_store_next    = offset_store;
    width_store_next     = width_store;
    height_store_next    = height_store;
    bits_store_next      = bits_store;
    stream_position_next = stream_position;
    row_byte_count_next  = row_byte_count;
    pad_count_next       = pad_count;
    row_count_next       = row_count;
    res_valid     = 1'b0;
    res_kind      = KIND_PIXEL;
    res_row_end   = 1'b0;
    res_image_end = 1'b0;
    res_err       = ERR_NONE;
    clear         = 1'b0;

    case (phase)
      PH_HEADER: begin
        if ((header_index == 6'd0 && ib_data != SIG_B) ||
            (header_index == 6'd1 && ib_data != SIG_M)) begin
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          res_err    = ERR_SIGNATURE;
          phase_next = PH_WAIT;
          clear      = ib_eos;
        end else begin
          // little-endian field capture, stores are zero at file start
          if (header_index inside {[6'd10:6'd13]}) begin
            offset_store_next[{lane, 3'b000} +: 8] = ib_data;
          end else if (header_index inside {[6'd18:6'd21]}) begin
            width_store_next[{lane, 3'b000} +: 8] = ib_data;
          end else if (header_index inside {[6'd22:6'd25]}) begin
            height_store_next[{lane, 3'b000} +: 8] = ib_data;
          end else if (header_index inside {[6'd28:6'd29]}) begin
            bits_store_next[{header_index[0], 3'b000} +: 8] = ib_data;
          end
          stream_position_next = pos_inc;
          if (header_index != HEADER_LAST_IDX) begin
            header_index_next = header_index + 6'd1;
            if (ib_eos) begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              res_err   = ERR_TRUNCATED;
              clear     = 1'b1;
            end
          end else if (offset_store < HEADER_LEN) begin
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_err    = ERR_OFFSET;
            phase_next = PH_WAIT;
            clear      = ib_eos;
          end else if (ib_eos && !empty) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_err   = ERR_TRUNCATED;
            clear     = 1'b1;
          end else begin
            res_valid     = 1'b1;
            res_kind      = KIND_HEADER;
            res_image_end = empty;
            if (ib_eos) begin
              clear = 1'b1;
            end else if (empty) begin
              phase_next = PH_WAIT;
            end else begin
              row_count_next = height_store;
              if (pos_inc == offset_store) begin
                row_byte_count_next = row_len;
                pad_count_next      = width_store[1:0];
                phase_next          = PH_ROW;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
        end
      end
      PH_SKIP: begin
        if (ib_eos) begin
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_err   = ERR_TRUNCATED;
          clear     = 1'b1;
        end else begin
          stream_position_next = pos_inc;
          if (pos_inc == offset_store) begin
            row_byte_count_next = row_len;
            pad_count_next      = width_store[1:0];
            phase_next          = PH_ROW;
          end
        end
      end
      PH_ROW: begin
        if (ib_eos && !last_image) begin
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_err   = ERR_TRUNCATED;
          clear     = 1'b1;
        end else begin
          res_valid     = 1'b1;
          res_kind      = KIND_PIXEL;
          res_row_end   = last_row_byte;
          res_image_end = last_image;
          if (row_byte_count != 33'd0) begin
            row_byte_count_next = row_byte_count - 33'd1;
          end
          if (last_row_byte) begin
            if (row_count != 32'd0) begin
              row_count_next = row_count - 32'd1;
            end
            if (last_image) begin
              phase_next = PH_WAIT;
            end else if (pad_count != 2'd0) begin
              phase_next = PH_PAD;
            end else begin
              row_byte_count_next = row_len;
              pad_count_next      = width_store[1:0];
              phase_next          = PH_ROW;
            end
          end
          clear = ib_eos;
        end
      end
      PH_PAD: begin
        if (ib_eos) begin
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_err   = ERR_TRUNCATED;
          clear     = 1'b1;
        end else begin
          pad_count_next = pad_dec;
          if (pad_dec == 2'd0) begin
            row_byte_count_next = row_len;
            pad_count_next      = width_store[1:0];
            phase_next          = PH_ROW;
          end
        end
      end
      default: begin
        // after an error or a full image, wait for the end of the file
        clear = ib_eos;
      end
    endcase

    // end of file: back to a clean header phase
    if (clear) begin
      phase_next           = PH_HEADER;
      header_index_next    = '0;
      offset_store_next    = '0;
      width_store_next     = '0;
      height_store_next    = '0;
      bits_store_next      = '0;
      stream_position_next = '0;
      row_byte_count_next  = '0;
      pad_count_next       = '0;
      row_count_next       = '0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ib_valid <= 1'b1;
    end else if (step) begin
      ib_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_data <= data_byte;
      ib_eos  <= end_of_stream;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_index    <= '0;
      offset_store    <= '0;
      width_store     <= '0;
      height_store    <= '0;
      bits_store      <= '0;
      stream_position <= '0;
      row_byte_count  <= '0;
      pad_count       <= '0;
      row_count       <= '0;
    end else if (step) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      offset_store    <= offset_store_next;
      width_store     <= width_store_next;
      height_store    <= height_store_next;
      bits_store      <= bits_store_next;
      stream_position <= stream_position_next;
      row_byte_count  <= row_byte_count_next;
      pad_count       <= pad_count_next;
      row_count       <= row_count_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res_valid;
    end
  end

  // result register payload, unused fields forced to zero
  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      result_kind <= res_kind;
      pixel_byte  <= (res_kind == KIND_PIXEL) ? ib_data : 8'd0;
      row_end     <= res_row_end;
      image_end   <= res_image_end;
      error_code  <= res_err;
      if (res_kind == KIND_HEADER) begin
        image_width       <= width_store;
        image_height      <= height_store;
        pixel_bits        <= bits_store;
        pixel_data_offset <= offset_store;
      end else begin
        image_width       <= '0;
        image_height      <= '0;
        pixel_bits        <= '0;
        pixel_data_offset <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/bsd_checker.sv
// port-level checks on the bmp stream deframer result words, bound to the top level
// depends on bsd_pkg and bmp_stream_deframer_assert.svh
`timescale 1ns / 1ps
`include "bmp_stream_deframer_assert.svh"

module bsd_checker
  import bsd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [7:0]  pixel_byte,
  input logic        row_end,
  input logic        image_end,
  input logic [31:0] pixel_data_offset,
  input logic [1:0]  error_code
);

  // a stalled word holds
  `BSD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(pixel_byte) && $stable(error_code), "stalled result word changed")

  // error words carry a real code and no pixel marks
  `BSD_ASSERT_IMP(a_err_code, out_valid && result_kind == KIND_ERROR, error_code != ERR_NONE && !row_end && !image_end, "error word with bad code or marks")

  // row marks only on pixel words
  `BSD_ASSERT_IMP(a_row_end_kind, out_valid && row_end, result_kind == KIND_PIXEL, "row end on a non-pixel word")

  // last pixel of the image also closes its row
  `BSD_ASSERT_IMP(a_image_end_row, out_valid && result_kind == KIND_PIXEL && image_end, row_end, "image end without row end")

  // header words only for an offset past the header
  `BSD_ASSERT_IMP(a_hdr_offset, out_valid && result_kind == KIND_HEADER, pixel_data_offset >= HEADER_LEN, "header word with offset inside header")

endmodule

bind bmp_stream_deframer bsd_checker u_bsd_checker (.*);

FILE: tb/sv/tb_bmp_stream_deframer.sv
`timescale 1ns / 1ps
// self-checking testbench for bmp_stream_deframer: directed table, then random bmp files
// byte-level predictor and result-word scoreboard; depends on bsd_pkg and the rtl top level

module tb_bmp_stream_deframer;
  import bsd_pkg::*;

  // header byte positions of the little-endian fields
  localparam int POS_OFFSET_LO = 10;
  localparam int POS_OFFSET_HI = 13;
  localparam int POS_WIDTH_LO  = 18;
  localparam int POS_WIDTH_HI  = 21;
  localparam int POS_HEIGHT_LO = 22;
  localparam int POS_HEIGHT_HI = 25;
  localparam int POS_BPP_LO    = 28;
  localparam int POS_BPP_HI    = 29;

  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 900;
  localparam int IDLE_PCT     = 35;

  typedef enum logic [2:0] {
    SEQ_HEADER, SEQ_SKIP, SEQ_ROW, SEQ_PAD, SEQ_DONE, SEQ_DRAIN
  } seq_phase_t;

  typedef enum int {
    SHAPE_IMAGE, SHAPE_EMPTY, SHAPE_OFFSET, SHAPE_HUGE, SHAPE_CUT_HEADER, SHAPE_NOISE
  } file_shape_t;

  // one result word as the block presents it
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pix;
    logic        row_end;
    logic        img_end;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] bpp;
    logic [31:0] data_off;
    err_t        err;
  } deframe_word_t;

  // one input byte, with a hand-written expectation where typed is set
  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       typed;
    logic       has;
    kind_t      kind;
    err_t       err;
  } stim_word_t;

  localparam int N_DIRECTED = 20;
  localparam stim_word_t DIRECTED_ROWS [N_DIRECTED] = '{
    // bad first byte on the last byte of a file
    '{8'h41, 1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_SIGNATURE},
    // bad second byte, then drain until end of stream
    '{SIG_B, 1'b0, 1'b1, 1'b0, KIND_PIXEL, ERR_NONE},
    '{8'h58, 1'b0, 1'b1, 1'b1, KIND_ERROR, ERR_SIGNATURE},
    '{8'hFF, 1'b0, 1'b1, 1'b0, KIND_PIXEL, ERR_NONE},
    '{SIG_B, 1'b0, 1'b1, 1'b0, KIND_PIXEL, ERR_NONE},
    '{8'h00, 1'b1, 1'b1, 1'b0, KIND_PIXEL, ERR_NONE},
    // stream ends inside the signature
    '{SIG_B, 1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_TRUNCATED},
    // signature error wins over truncation on the same byte
    '{SIG_B, 1'b0, 1'b1, 1'b0, KIND_PIXEL, ERR_NONE},
    '{SIG_B, 1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_SIGNATURE},
    '{SIG_B, 1'b0, 1'b1, 1'b0, KIND_PIXEL, ERR_NONE},
    '{SIG_M, 1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_TRUNCATED},
    // a few header bytes left to the predictor, then truncation
    '{SIG_B, 1'b0, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
    '{SIG_M, 1'b0, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
    '{8'hAA, 1'b0, 1'b0, 1'b0, KIND_PIXEL, ERR_NONE},
    '{8'h55, 1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_TRUNCATED},
    // zero first byte, signature byte ignored in drain
    '{8'h00, 1'b0, 1'b1, 1'b1, KIND_ERROR, ERR_SIGNATURE},
    '{SIG_M, 1'b1, 1'b1, 1'b0, KIND_PIXEL, ERR_NONE},
    '{8'hFF, 1'b1, 1'b1, 1'b1, KIND_ERROR, ERR_SIGNATURE}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = 8'h00;
  logic               end_of_stream = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         result_kind;
  logic [7:0]         pixel_byte;
  logic               row_end;
  logic               image_end;
  logic signed [31:0] image_width;
  logic signed [31:0] image_height;
  logic [15:0]        pixel_bits;
  logic [31:0]        pixel_data_offset;
  logic [1:0]         error_code;

  stim_word_t    byte_q [$];
  deframe_word_t pending_q [$];
  int            send_idx = 0;
  int            in_count = 0;
  int            fail_count = 0;
  int            random_bytes = 0;
  int            stall_left = 0;
  logic          stall_done = 1'b0;
  logic          calm;

  // predictor state
  seq_phase_t  ph;
  logic [5:0]  hdr_idx;
  logic [31:0] fshift;
  logic [31:0] off_acc;
  logic [31:0] wid_acc;
  logic [31:0] hgt_acc;
  logic [15:0] bpp_acc;
  logic [31:0] pos;
  logic [32:0] row_left;
  logic [1:0]  pad_left;
  logic [31:0] rows_left;

  bmp_stream_deframer i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .data_byte         (data_byte),
    .end_of_stream     (end_of_stream),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .result_kind       (result_kind),
    .pixel_byte        (pixel_byte),
    .row_end           (row_end),
    .image_end         (image_end),
    .image_width       (image_width),
    .image_height      (image_height),
    .pixel_bits        (pixel_bits),
    .pixel_data_offset (pixel_data_offset),
    .error_code        (error_code)
  );

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // back to the start of a file
  function automatic void clear_parser();
    ph        = SEQ_HEADER;
    hdr_idx   = '0;
    fshift    = '0;
    off_acc   = '0;
    wid_acc   = '0;
    hgt_acc   = '0;
    bpp_acc   = '0;
    pos       = '0;
    row_left  = '0;
    pad_left  = '0;
    rows_left = '0;
  endfunction

  function automatic void begin_row();
    row_left = {1'b0, wid_acc} * 33'd3;
    pad_left = wid_acc[1:0];
    ph       = SEQ_ROW;
  endfunction

  // error word; drain unless the file ends here
  function automatic deframe_word_t error_word(err_t code, logic eos);
    deframe_word_t w;
    w      = '0;
    w.kind = KIND_ERROR;
    w.err  = code;
    if (eos) clear_parser();
    else ph = SEQ_DRAIN;
    return w;
  endfunction

  // one byte through the deframer; returns 1 when it yields a word
  function automatic logic predict_byte(input logic [7:0] b, input logic eos,
                                        output deframe_word_t w);
    logic last_row;
    logic last_img;
    logic w_pos;
    logic h_pos;
    logic empty;
    w = '0;
    case (ph)
      SEQ_HEADER: begin
        if ((hdr_idx == 0 && b != SIG_B) || (hdr_idx == 1 && b != SIG_M)) begin
          w = error_word(ERR_SIGNATURE, eos);
          return 1'b1;
        end
        if (hdr_idx == POS_OFFSET_LO || hdr_idx == POS_WIDTH_LO ||
            hdr_idx == POS_HEIGHT_LO || hdr_idx == POS_BPP_LO) fshift = '0;
        if (hdr_idx >= POS_OFFSET_LO && hdr_idx <= POS_OFFSET_HI)
          off_acc |= 32'(b) << fshift;
        else if (hdr_idx >= POS_WIDTH_LO && hdr_idx <= POS_WIDTH_HI)
          wid_acc |= 32'(b) << fshift;
        else if (hdr_idx >= POS_HEIGHT_LO && hdr_idx <= POS_HEIGHT_HI)
          hgt_acc |= 32'(b) << fshift;
        else if (hdr_idx >= POS_BPP_LO && hdr_idx <= POS_BPP_HI)
          bpp_acc |= 16'(32'(b) << fshift);
        fshift = (fshift + 32'd8) & 32'd31;
        pos    = pos + 32'd1;
        if (hdr_idx != HEADER_LAST_IDX) begin
          hdr_idx = hdr_idx + 6'd1;
          if (eos) begin
            w = error_word(ERR_TRUNCATED, 1'b1);
            return 1'b1;
          end
          return 1'b0;
        end
        if (off_acc < HEADER_LEN) begin
          w = error_word(ERR_OFFSET, eos);
          return 1'b1;
        end
        w_pos = !wid_acc[31] && wid_acc != 0;
        h_pos = !hgt_acc[31] && hgt_acc != 0;
        empty = !(w_pos && h_pos);
        if (eos && !empty) begin
          w = error_word(ERR_TRUNCATED, 1'b1);
          return 1'b1;
        end
        w.kind     = KIND_HEADER;
        w.img_end  = empty;
        w.width    = wid_acc;
        w.height   = hgt_acc;
        w.bpp      = bpp_acc;
        w.data_off = off_acc;
        if (eos) clear_parser();
        else if (empty) ph = SEQ_DONE;
        else begin
          rows_left = hgt_acc;
          if (pos == off_acc) begin_row();
          else ph = SEQ_SKIP;
        end
        return 1'b1;
      end
      SEQ_SKIP: begin
        if (eos) begin
          w = error_word(ERR_TRUNCATED, 1'b1);
          return 1'b1;
        end
        pos = pos + 32'd1;
        if (pos == off_acc) begin_row();
        return 1'b0;
      end
      SEQ_ROW: begin
        last_row = row_left <= 33'd1;
        last_img = last_row && rows_left <= 32'd1;
        if (eos && !last_img) begin
          w = error_word(ERR_TRUNCATED, 1'b1);
          return 1'b1;
        end
        w.kind    = KIND_PIXEL;
        w.pix     = b;
        w.row_end = last_row;
        w.img_end = last_img;
        if (row_left != 0) row_left = row_left - 33'd1;
        if (last_row) begin
          if (rows_left != 0) rows_left = rows_left - 32'd1;
          if (last_img) ph = SEQ_DONE;
          else if (pad_left != 0) ph = SEQ_PAD;
          else begin_row();
        end
        if (eos) clear_parser();
        return 1'b1;
      end
      SEQ_PAD: begin
        if (eos) begin
          w = error_word(ERR_TRUNCATED, 1'b1);
          return 1'b1;
        end
        pad_left = pad_left - 2'd1;
        if (pad_left == 0) begin_row();
        return 1'b0;
      end
      default: begin
        if (eos) clear_parser();
        return 1'b0;
      end
    endcase
  endfunction

  // one bmp file, possibly broken, queued byte by byte
  task automatic gen_file(input file_shape_t shape);
    logic [7:0]  fb [$];
    logic [31:0] off;
    logic [31:0] wid;
    logic [31:0] hgt;
    logic [15:0] bpp;
    int unsigned cut;
    int unsigned n;
    int unsigned r;
    stim_word_t  s;
    wid = $urandom_range(6, 1);
    hgt = $urandom_range(3, 1);
    off = HEADER_LEN + (($urandom_range(1) == 0) ? 32'd0 : 32'($urandom_range(6, 1)));
    bpp = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd24;
    case (shape)
      SHAPE_EMPTY: begin
        r = $urandom_range(3);
        if (r < 2) begin
          wid = (r == 0) ? 32'd0 :
                (32'h8000_0000 | (($urandom_range(1) == 0) ? 32'd0 : $urandom));
          hgt = $urandom;
        end else begin
          hgt = (r == 2) ? 32'd0 :
                (32'h8000_0000 | (($urandom_range(1) == 0) ? 32'd0 : $urandom));
          wid = $urandom;
        end
      end
      SHAPE_OFFSET: begin
        if ($urandom_range(2) == 0) off = ($urandom_range(1) == 0) ? 32'd0 : 32'd53;
        else off = $urandom_range(53, 0);
        wid = $urandom;
        hgt = $urandom;
      end
      SHAPE_HUGE: begin
        bpp = ($urandom_range(1) == 0) ? 16'hFFFF : 16'h0000;
        r = $urandom_range(2);
        if (r == 0) begin
          wid = 32'h7FFF_FFFF;
          hgt = ($urandom_range(1) == 0) ? 32'h7FFF_FFFF : (($urandom & 32'h7FFF_FFFF) | 32'd1);
          off = HEADER_LEN;
        end else begin
          off = (r == 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
        end
      end
      default: ;
    endcase
    if (shape == SHAPE_NOISE) begin
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) fb.push_back(8'($urandom));
      if ($urandom_range(1) == 0) fb[0] = SIG_B;
      cut = fb.size() - 1;
    end else begin
      // header with the chosen fields, random filler elsewhere
      for (int i = 0; i < HEADER_LEN; i++) begin
        if (i == 0) fb.push_back(SIG_B);
        else if (i == 1) fb.push_back(SIG_M);
        else if (i >= POS_OFFSET_LO && i <= POS_OFFSET_HI)
          fb.push_back(off[8*(i-POS_OFFSET_LO) +: 8]);
        else if (i >= POS_WIDTH_LO && i <= POS_WIDTH_HI)
          fb.push_back(wid[8*(i-POS_WIDTH_LO) +: 8]);
        else if (i >= POS_HEIGHT_LO && i <= POS_HEIGHT_HI)
          fb.push_back(hgt[8*(i-POS_HEIGHT_LO) +: 8]);
        else if (i >= POS_BPP_LO && i <= POS_BPP_HI)
          fb.push_back(bpp[8*(i-POS_BPP_LO) +: 8]);
        else fb.push_back(8'($urandom));
      end
      case (shape)
        SHAPE_IMAGE: begin
          for (int i = HEADER_LEN; i < off; i++) fb.push_back(8'($urandom));
          for (int row = 0; row < hgt; row++) begin
            for (int i = 0; i < 3 * wid; i++) fb.push_back(8'($urandom));
            if (row + 1 < hgt)
              for (int i = 0; i < wid[1:0]; i++) fb.push_back(8'($urandom));
          end
          r = $urandom_range(99);
          if (r < 70) cut = fb.size() - 1;
          else if (r < 85) begin
            n = $urandom_range(5, 1);
            for (int i = 0; i < n; i++) fb.push_back(8'($urandom));
            cut = fb.size() - 1;
          end else cut = $urandom_range(fb.size() - 2, 0);
        end
        SHAPE_HUGE: begin
          for (int i = 0; i < 40; i++) fb.push_back(8'($urandom));
          cut = $urandom_range(fb.size() - 1, HEADER_LEN - 1);
        end
        SHAPE_CUT_HEADER: cut = $urandom_range(HEADER_LEN - 1, 2);
        default: begin
          n = $urandom_range(4, 0);
          for (int i = 0; i < n; i++) fb.push_back(8'($urandom));
          cut = fb.size() - 1;
        end
      endcase
    end
    for (int i = 0; i <= cut; i++) begin
      s     = '0;
      s.b   = fb[i];
      s.eos = (i == cut);
      byte_q.push_back(s);
      random_bytes++;
    end
  endtask

  // field compare with report
  function automatic void cmp_field(input string what, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  assign calm = (in_count >= CALM_FROM) && (in_count < CALM_TO);

  // sender: one word offered at a time, held until taken
  always @(posedge clk) begin : byte_sender
    if (!rst && (!in_valid || in_ready)) begin
      if (send_idx < byte_q.size() && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        data_byte     <= byte_q[send_idx].b;
        end_of_stream <= byte_q[send_idx].eos;
        in_valid      <= 1'b1;
        send_idx      <= send_idx + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the input
  always @(posedge clk) begin : result_taker
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && in_count >= HOLD_AT) begin
      out_ready  <= 1'b0;
      stall_left <= HOLD_CYCLES;
      stall_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // scoreboard: check each result word, predict each accepted byte
  always @(posedge clk) begin : scoreboard
    deframe_word_t want;
    deframe_word_t pred;
    logic          has;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual kind %0d", $time, result_kind);
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          cmp_field("result_kind", 32'(want.kind), 32'(result_kind));
          cmp_field("pixel_byte", 32'(want.pix), 32'(pixel_byte));
          cmp_field("row_end", 32'(want.row_end), 32'(row_end));
          cmp_field("image_end", 32'(want.img_end), 32'(image_end));
          cmp_field("image_width", want.width, image_width);
          cmp_field("image_height", want.height, image_height);
          cmp_field("pixel_bits", 32'(want.bpp), 32'(pixel_bits));
          cmp_field("pixel_data_offset", want.data_off, pixel_data_offset);
          cmp_field("error_code", 32'(want.err), 32'(error_code));
        end
      end
      if (in_valid && in_ready) begin
        has = predict_byte(data_byte, end_of_stream, pred);
        if (byte_q[in_count].typed) begin
          if (byte_q[in_count].has) begin
            want      = '0;
            want.kind = byte_q[in_count].kind;
            want.err  = byte_q[in_count].err;
            pending_q.push_back(want);
          end
        end else if (has) begin
          pending_q.push_back(pred);
        end
        in_count <= in_count + 1;
      end
    end
  end

  initial begin : main_seq
    int          file_no;
    int unsigned r;
    file_shape_t shape;
    clear_parser();
    foreach (DIRECTED_ROWS[i]) byte_q.push_back(DIRECTED_ROWS[i]);
    // every shape once, then a weighted mix leaning on well-formed files
    file_no = 0;
    while (random_bytes < RANDOM_ITEMS) begin
      if (file_no < 6) shape = file_shape_t'(file_no);
      else begin
        r = $urandom_range(99);
        shape = (r < 50) ? SHAPE_IMAGE :
                (r < 60) ? SHAPE_EMPTY :
                (r < 68) ? SHAPE_OFFSET :
                (r < 76) ? SHAPE_HUGE :
                (r < 86) ? SHAPE_CUT_HEADER : SHAPE_NOISE;
      end
      gen_file(shape);
      file_no++;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (send_idx < byte_q.size() || in_valid) @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
